// ===== src/shms_pkg.sv =====
package shms_pkg;

  localparam int NUM_LAYERS  = 4;
  localparam int NUM_ROWS    = 32;
  localparam int LIST_DEPTH  = 32;
  localparam int NUM_ENDS    = NUM_LAYERS * NUM_ROWS * 2;
  localparam int LIST_W      = $clog2(NUM_ENDS);
  localparam int NUM_ENTRIES = NUM_ENDS * LIST_DEPTH;
  localparam int ADDR_W      = $clog2(NUM_ENTRIES);
  localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W       = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  // shared divider sizing: 48-bit dividend covers 16b x 32b merge numerator
  localparam int DIV_W = 48;
  localparam int DSR_W = 33;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd3;

  localparam logic [15:0] ATTEN_RST  = 16'd15000;
  localparam logic [15:0] DELAY_RST  = 16'd55188;
  localparam logic [15:0] WINDOW_RST = 16'd800;
  localparam logic [31:0] THRESH_RST = 32'd50000;

  localparam logic KIND_DEPOSIT = 1'b0;
  localparam logic KIND_READOUT = 1'b1;
  localparam logic END_LEFT     = 1'b0;
  localparam logic END_RIGHT    = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [1:0]         layer;
    logic [4:0]         row;
    logic signed [15:0] local_x;
    logic signed [31:0] step_time;
    logic [31:0]        deposit_energy;
  } in_t;

  typedef struct packed {
    logic               paddle_end;
    logic               hit_valid;
    logic signed [31:0] hit_time;
    logic [31:0]        hit_energy;
    logic               overflowed;
    logic               last;
  } out_t;

endpackage

// ===== src/scintillator_hit_merge_store_core.sv =====
// Channel  | Ports                          | Transfer
// ---------+--------------------------------+-----------------------------------
// input    | start, busy, in_data           | edge with start=1 and busy=0
// result   | out_valid, out_data            | every cycle out_valid=1, no stall
// config   | cfg_we, cfg_idx, cfg_wdata     | every edge with cfg_we=1
//
// One item at a time. A deposit: offset by reciprocal multiply, a divider pass for
// the attenuation exponent, then per end a square-and-multiply, a search over the
// stored hits and, on a match, another divider pass for the time.
// A readout scans both ends and gives one result per stored hit at or above the
// threshold, or a single empty result when there is none.
// Reset (rst_n low, synchronous) clears control, config and the per-end
// valid bits; hit memories are not cleared and need no sweep.
// Results cannot be stalled: each is shown for exactly one cycle.
module scintillator_hit_merge_store_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  shms_pkg::in_t                       in_data,
  output logic                                out_valid,
  output shms_pkg::out_t                      out_data,
  input  logic                                cfg_we,
  input  logic [shms_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [shms_pkg::CFG_DAT_W-1:0]      cfg_wdata
);
  import shms_pkg::*;

  localparam logic [DIV_W-1:0] OFS_HALF  = DIV_W'(3276800);
  localparam logic [12:0]      OFS_RECIP = 13'd5243;   // ceil(2^19 / 100)
  localparam logic [31:0]      C_DEC     = 32'd64520;  // e^-1/64, Q16.16
  localparam logic [31:0]      C_GROW    = 32'd66568;  // e^+1/64, Q16.16
  localparam logic [31:0]      Q_ONE     = 32'd65536;

  typedef struct packed {
    logic signed [31:0] t;
    logic [31:0]        e;
  } ent_t;

  typedef struct packed {
    logic             ovf;
    logic [CNT_W-1:0] n;
  } cnt_ent_t;

  typedef enum logic [4:0] {
    S_IDLE, S_PMUL, S_OFS, S_ATTW, S_EINIT, S_EXP, S_XR, S_XRW, S_XB,
    S_XBW, S_EMUL, S_EMULW, S_CNTW, S_SRD, S_SCK, S_MMUL, S_MDIV, S_MDW,
    S_RCNT, S_RCW, S_RRD, S_RCK, S_RFIN, S_RCLR
  } state_t;

  // rounding Q16 product to 32 bits, saturating
  function automatic logic [31:0] qround(input logic [63:0] p);
    logic [64:0] s;
    s = {1'b0, p} + 65'd32768;
    return (|s[64:48]) ? 32'hFFFF_FFFF : s[47:16];
  endfunction

  function automatic logic [31:0] sat_time(input logic [33:0] v);
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) return v[31:0];
    return v[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [LIST_W-1:0] lst,
                                               input logic [IDX_W-1:0] idx);
    return ADDR_W'(lst) * ADDR_W'(LIST_DEPTH) + ADDR_W'(idx);
  endfunction

  // config
  logic [15:0] atten_r, delay_r, window_r;
  logic [31:0] thresh_r;

  // control
  state_t      state_r;
  logic        end_r;
  logic        pend_r;
  logic        out_valid_r;

  // item and working registers
  in_t                in_r;
  logic [LIST_W-1:0]  list_r;
  logic [63:0]        prod_r;
  logic signed [16:0] q_r;
  logic [23:0]        a_r, aw_r;
  logic [31:0]        r_r, b_r;
  logic signed [31:0] tend_r;
  logic [31:0]        eend_r;
  logic [CNT_W-1:0]   n_r, idx_r;
  logic               ovf_r, ovfa_r;
  logic [15:0]        dmag_r;
  logic               dneg_r;
  logic signed [31:0] mt_r;
  logic [31:0]        me_r;
  out_t               pend_data_r;
  out_t               out_r;

  // memories
  ent_t               ent_mem [NUM_ENTRIES];
  ent_t               ent_q_r;
  cnt_ent_t           cnt_mem [NUM_ENDS];
  cnt_ent_t           cnt_q_r;
  logic [NUM_ENDS-1:0] cnt_vld_r;
  logic               cnt_vq_r;

  logic               ent_we;
  logic [ADDR_W-1:0]  ent_waddr, ent_raddr;
  ent_t               ent_wdata;
  logic               cnt_we;
  logic [LIST_W-1:0]  cnt_waddr, cnt_raddr;
  cnt_ent_t           cnt_wdata;

  // divider hookup
  logic               div_start, div_done;
  logic [DIV_W-1:0]   div_dvd, div_quo;
  logic [DSR_W-1:0]   div_dsr;

  // derived values
  logic [LIST_W-1:0]  list_cur;
  logic [ADDR_W-1:0]  addr_cur;
  logic               item_ok;
  logic signed [32:0] p_calc;
  logic [32:0]        pabs;
  logic [DIV_W-1:0]   ofs_dvd;
  logic [28:0]        ofs_prod;
  logic [15:0]        ofs_q;
  logic [15:0]        att_len;
  logic [16:0]        ax;
  logic [DIV_W-1:0]   att_dvd;
  logic               grow;
  logic [33:0]        q_ext, tsum;
  logic [32:0]        diff, dabs;
  logic [32:0]        esum;
  logic [31:0]        esat;
  logic [33:0]        shift_ext, mtsum;
  cnt_ent_t           cnt_rd;

  assign list_cur = list_r + LIST_W'(end_r);
  assign addr_cur = addr_of(list_cur, idx_r[IDX_W-1:0]);
  assign item_ok  = (int'(in_data.layer) < NUM_LAYERS) && (int'(in_data.row) < NUM_ROWS);

  always_comb begin
    p_calc  = in_r.local_x * $signed({1'b0, delay_r});
    pabs    = prod_r[32] ? 33'(~prod_r[32:0] + 33'd1) : prod_r[32:0];
    ofs_dvd = DIV_W'(pabs) + OFS_HALF;
    // divide by 6553600 = 65536 * 100: drop 16 bits, then reciprocal for /100
    ofs_prod = ofs_dvd[31:16] * OFS_RECIP;
    ofs_q    = {6'd0, ofs_prod[28:19]};
    att_len = (atten_r == 16'd0) ? 16'd1 : atten_r;
    ax      = in_r.local_x[15] ? 17'(~{in_r.local_x[15], in_r.local_x} + 17'd1)
                               : {1'b0, in_r.local_x};
    att_dvd = DIV_W'({ax, 6'b0}) + DIV_W'(att_len >> 1);
    // left end looks toward +x: it grows when x is negative
    grow    = (end_r == END_LEFT) ? in_r.local_x[15] : ~in_r.local_x[15];
    q_ext   = 34'(q_r);
    tsum    = (end_r == END_LEFT) ? 34'(in_r.step_time) + q_ext
                                  : 34'(in_r.step_time) - q_ext;
    diff    = 33'(tend_r) - 33'(ent_q_r.t);
    dabs    = diff[32] ? ~diff + 33'd1 : diff;
    esum    = {1'b0, me_r} + {1'b0, eend_r};
    esat    = esum[32] ? 32'hFFFF_FFFF : esum[31:0];
    shift_ext = dneg_r ? ~34'(div_quo[15:0]) + 34'd1 : 34'(div_quo[15:0]);
    mtsum   = 34'(mt_r) + shift_ext;
    cnt_rd  = cnt_vq_r ? cnt_q_r : '0;
  end

  // memory and divider control per state
  always_comb begin
    ent_we    = 1'b0;
    ent_waddr = addr_cur;
    ent_raddr = addr_cur;
    ent_wdata = '{t: tend_r, e: eend_r};
    cnt_we    = 1'b0;
    cnt_waddr = list_cur;
    cnt_raddr = list_cur;
    cnt_wdata = '{ovf: ovf_r, n: n_r + 1'b1};
    div_start = 1'b0;
    div_dvd   = att_dvd;
    div_dsr   = DSR_W'(att_len);
    unique case (state_r)
      S_OFS: div_start = 1'b1;
      S_SRD: begin
        if (idx_r == n_r) begin
          cnt_we = 1'b1;
          if (n_r < CNT_W'(LIST_DEPTH)) begin
            ent_we = 1'b1;
          end else begin
            cnt_wdata = '{ovf: 1'b1, n: n_r};
          end
        end
      end
      S_MDIV: begin
        div_start = 1'b1;
        div_dvd   = prod_r[DIV_W-1:0];
        div_dsr   = esum;
      end
      S_MDW: begin
        ent_we    = div_done;
        ent_wdata = '{t: sat_time(mtsum), e: esat};
      end
      S_RFIN: begin
        cnt_we    = 1'b1;
        cnt_waddr = list_r;
        cnt_wdata = '0;
      end
      S_RCLR: begin
        cnt_we    = 1'b1;
        cnt_waddr = list_r + 1'b1;
        cnt_wdata = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
    ent_q_r <= ent_mem[ent_raddr];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    cnt_q_r  <= cnt_mem[cnt_raddr];
    cnt_vq_r <= cnt_vld_r[cnt_raddr];
  end

  // an end without its valid bit reads as empty, no overflow
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r <= '0;
    end else if (cnt_we) begin
      cnt_vld_r[cnt_waddr] <= 1'b1;
    end
  end

  shms_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      end_r       <= END_LEFT;
      atten_r     <= ATTEN_RST;
      delay_r     <= DELAY_RST;
      window_r    <= WINDOW_RST;
      thresh_r    <= THRESH_RST;
    end else begin
      out_valid_r <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_ATTEN:  atten_r  <= cfg_wdata[15:0];
          CFG_DELAY:  delay_r  <= cfg_wdata[15:0];
          CFG_WINDOW: window_r <= cfg_wdata[15:0];
          CFG_THRESH: thresh_r <= cfg_wdata;
          default: ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            in_r   <= in_data;
            list_r <= LIST_W'((int'(in_data.layer) * NUM_ROWS + int'(in_data.row)) * 2);
            end_r  <= END_LEFT;
            pend_r <= 1'b0;
            ovfa_r <= 1'b0;
            if (in_data.kind == KIND_READOUT) begin
              if (item_ok) begin
                state_r <= S_RCNT;
              end else begin
                out_valid_r <= 1'b1;
                out_r       <= '{paddle_end: END_LEFT, hit_valid: 1'b0, hit_time: '0,
                                 hit_energy: '0, overflowed: 1'b0, last: 1'b1};
              end
            end else if (item_ok && in_data.deposit_energy != 32'd0) begin
              state_r <= S_PMUL;
            end
          end
        end

        // ---- deposit: propagation offset and attenuation exponent ----
        S_PMUL: begin
          prod_r  <= 64'(p_calc);
          state_r <= S_OFS;
        end
        S_OFS: begin
          // exponent divide starts here, offset is ready from the product
          q_r     <= prod_r[32] ? -$signed({1'b0, ofs_q}) : $signed({1'b0, ofs_q});
          state_r <= S_ATTW;
        end
        S_ATTW: begin
          if (div_done) begin
            a_r     <= div_quo[23:0];
            state_r <= S_EINIT;
          end
        end

        // ---- per end: factor = c^a by square and multiply ----
        S_EINIT: begin
          aw_r    <= a_r;
          r_r     <= Q_ONE;
          b_r     <= grow ? C_GROW : C_DEC;
          state_r <= S_EXP;
        end
        S_EXP: begin
          if (aw_r == '0) state_r <= S_EMUL;
          else if (aw_r[0]) state_r <= S_XR;
          else state_r <= S_XB;
        end
        S_XR: begin
          prod_r  <= r_r * b_r;
          state_r <= S_XRW;
        end
        S_XRW: begin
          r_r     <= qround(prod_r);
          state_r <= S_XB;
        end
        S_XB: begin
          prod_r  <= b_r * b_r;
          state_r <= S_XBW;
        end
        S_XBW: begin
          b_r     <= qround(prod_r);
          aw_r    <= aw_r >> 1;
          state_r <= S_EXP;
        end
        S_EMUL: begin
          prod_r  <= in_r.deposit_energy * r_r;
          state_r <= S_EMULW;
        end
        S_EMULW: begin
          eend_r  <= qround(prod_r);
          tend_r  <= sat_time(tsum);
          state_r <= S_CNTW;             // count read issued this cycle
        end
        S_CNTW: begin
          n_r   <= cnt_rd.n;
          ovf_r <= cnt_rd.ovf;
          idx_r <= '0;
          if (eend_r != 32'd0) begin
            state_r <= S_SRD;
          end else if (end_r == END_LEFT) begin
            end_r   <= END_RIGHT;
            state_r <= S_EINIT;
          end else begin
            state_r <= S_IDLE;
          end
        end

        // ---- list search: first hit inside the window ----
        S_SRD: begin
          if (idx_r == n_r) begin
            // append or overflow written by the control block
            if (end_r == END_LEFT) begin
              end_r   <= END_RIGHT;
              state_r <= S_EINIT;
            end else begin
              state_r <= S_IDLE;
            end
          end else begin
            state_r <= S_SCK;
          end
        end
        S_SCK: begin
          if (dabs < {17'd0, window_r}) begin
            dmag_r  <= dabs[15:0];
            dneg_r  <= diff[32];
            mt_r    <= ent_q_r.t;
            me_r    <= ent_q_r.e;
            state_r <= S_MMUL;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_SRD;
          end
        end
        S_MMUL: begin
          prod_r  <= dmag_r * eend_r;
          state_r <= S_MDIV;
        end
        S_MDIV: state_r <= S_MDW;
        S_MDW: begin
          if (div_done) begin
            if (end_r == END_LEFT) begin
              end_r   <= END_RIGHT;
              state_r <= S_EINIT;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end

        // ---- readout: one result held back so the final one gets last ----
        S_RCNT: state_r <= S_RCW;
        S_RCW: begin
          n_r     <= cnt_rd.n;
          ovf_r   <= cnt_rd.ovf;
          ovfa_r  <= ovfa_r | cnt_rd.ovf;
          idx_r   <= '0;
          state_r <= S_RRD;
        end
        S_RRD: begin
          if (idx_r == n_r) begin
            if (end_r == END_LEFT) begin
              end_r   <= END_RIGHT;
              state_r <= S_RCNT;
            end else begin
              state_r <= S_RFIN;
            end
          end else begin
            state_r <= S_RCK;
          end
        end
        S_RCK: begin
          if (ent_q_r.e >= thresh_r) begin
            if (pend_r) begin
              out_valid_r <= 1'b1;
              out_r       <= pend_data_r;
            end
            pend_r      <= 1'b1;
            pend_data_r <= '{paddle_end: end_r, hit_valid: 1'b1, hit_time: ent_q_r.t,
                             hit_energy: ent_q_r.e, overflowed: ovf_r, last: 1'b0};
          end
          idx_r   <= idx_r + 1'b1;
          state_r <= S_RRD;
        end
        S_RFIN: begin
          out_valid_r <= 1'b1;
          if (pend_r) begin
            out_r <= '{paddle_end: pend_data_r.paddle_end,
                       hit_valid: pend_data_r.hit_valid,
                       hit_time: pend_data_r.hit_time,
                       hit_energy: pend_data_r.hit_energy,
                       overflowed: pend_data_r.overflowed, last: 1'b1};
          end else begin
            out_r <= '{paddle_end: END_LEFT, hit_valid: 1'b0, hit_time: '0,
                       hit_energy: '0, overflowed: ovfa_r, last: 1'b1};
          end
          pend_r  <= 1'b0;
          state_r <= S_RCLR;
        end
        S_RCLR: state_r <= S_IDLE;

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== src/shms_div.sv =====
module shms_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [shms_pkg::DIV_W-1:0]   dividend,
  input  logic [shms_pkg::DSR_W-1:0]   divisor,
  output logic                         done,
  output logic [shms_pkg::DIV_W-1:0]   quotient
);
  import shms_pkg::*;

  localparam int STEP_W = $clog2(DIV_W + 1);

  logic              run_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DIV_W-1:0]  quo_r;
  logic [DSR_W:0]    rem_r;
  logic [DSR_W-1:0]  dsr_r;

  logic [DSR_W:0]    rem_sh;
  logic              fits;
  logic [DSR_W:0]    rem_nxt;
  logic [DIV_W-1:0]  quo_nxt;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh  = {rem_r[DSR_W-1:0], quo_r[DIV_W-1]};
    fits    = rem_sh >= {1'b0, dsr_r};
    rem_nxt = fits ? rem_sh - {1'b0, dsr_r} : rem_sh;
    quo_nxt = {quo_r[DIV_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
        quo_r  <= dividend;
        rem_r  <= '0;
        dsr_r  <= divisor;
      end else if (run_r) begin
        quo_r  <= quo_nxt;
        rem_r  <= rem_nxt;
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(DIV_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== tb/tb_scintillator_hit_merge_store_core.sv =====
module tb_scintillator_hit_merge_store_core;
  timeunit 1ns;
  timeprecision 1ps;
  import shms_pkg::*;

  localparam int  CYCLE_LIMIT = 1000000;
  // quiet time before register writes
  localparam int  SETTLE      = 700;
  localparam longint SAT_U32  = 64'hFFFF_FFFF;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  in_t                  in_data = '0;
  logic                 out_valid;
  out_t                 out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_ATTEN;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  always #6 clk = ~clk;

  scintillator_hit_merge_store_core u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Paddle store model: own copy of the config and the per-end hit lists.
  // ---------------------------------------------------------------------------
  int unsigned atten_len, delay_pos, window, threshold;
  int          hit_t  [NUM_ENDS][LIST_DEPTH];
  int unsigned hit_e  [NUM_ENDS][LIST_DEPTH];
  int unsigned hit_n  [NUM_ENDS];
  bit          ovf_mk [NUM_ENDS];

  out_t pending_hits[$];  // readout results not yet seen on the port
  out_t fresh_hits[$];    // results of the item just transferred
  int   mismatches = 0;
  int   items_done = 0;
  int   hits_seen  = 0;
  int   cycles     = 0;

  function automatic logic [63:0] q16_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] r;
    r = ((128'(a) * 128'(b)) + 128'd32768) >> 16;
    return (r > 128'(SAT_U32)) ? 64'(SAT_U32) : r[63:0];
  endfunction

  // c^a in Q16.16, c = e^-1/64 (toward end) or e^+1/64 (far end)
  function automatic logic [63:0] atten_factor(logic [31:0] a, bit grow);
    logic [63:0] r, b;
    r = 64'd65536;
    b = grow ? 64'd66568 : 64'd64520;
    while (a != 0) begin
      if (a[0]) r = q16_mul(r, b);
      b = q16_mul(b, b);
      a = a >> 1;
    end
    return r;
  endfunction

  function automatic logic [31:0] end_energy(logic [31:0] dep, logic [63:0] f);
    logic [127:0] r;
    r = ((128'(dep) * 128'(f)) + 128'd32768) >> 16;
    return (r > 128'(SAT_U32)) ? 32'hFFFF_FFFF : r[31:0];
  endfunction

  function automatic int sat_s32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return int'(v);
  endfunction

  function automatic void merge_into_end(int list, int t, int unsigned e);
    longint d, ad, sum, shift;
    if (e == 0) return;
    for (int i = 0; i < hit_n[list]; i++) begin
      d  = longint'(t) - longint'(hit_t[list][i]);
      ad = (d < 0) ? -d : d;
      if (ad < longint'(window)) begin
        sum   = longint'(hit_e[list][i]) + longint'(e);
        shift = (d * longint'(e)) / sum;   // truncates toward zero
        hit_t[list][i] = sat_s32(longint'(hit_t[list][i]) + shift);
        hit_e[list][i] = (sum > SAT_U32) ? 32'hFFFF_FFFF : sum[31:0];
        return;
      end
    end
    if (hit_n[list] < LIST_DEPTH) begin
      hit_t[list][hit_n[list]] = t;
      hit_e[list][hit_n[list]] = e;
      hit_n[list]++;
    end else begin
      ovf_mk[list] = 1'b1;
    end
  endfunction

  // Applies one transferred item to the model, leaves its results in fresh_hits.
  function automatic void predict_paddle(in_t it);
    longint xs, ts, p, ap, q, ln, ax, a;
    int     left;
    out_t   r;
    fresh_hits.delete();
    left = (int'(it.layer) * NUM_ROWS + int'(it.row)) * 2;
    if (it.kind == KIND_DEPOSIT) begin
      if (it.deposit_energy == 0) return;
      xs = it.local_x;
      ts = it.step_time;
      p  = xs * longint'(delay_pos);
      ap = (p < 0) ? -p : p;
      q  = (ap + 3276800) / 6553600;
      if (p < 0) q = -q;
      ln = (atten_len == 0) ? 1 : longint'(atten_len);
      ax = (xs < 0) ? -xs : xs;
      a  = (ax * 64 + ln / 2) / ln;
      merge_into_end(left, sat_s32(ts + q),
                     end_energy(it.deposit_energy, atten_factor(a[31:0], xs < 0)));
      merge_into_end(left + 1, sat_s32(ts - q),
                     end_energy(it.deposit_energy, atten_factor(a[31:0], xs >= 0)));
    end else begin
      for (int s = 0; s < 2; s++)
        for (int i = 0; i < hit_n[left+s]; i++)
          if (hit_e[left+s][i] >= threshold) begin
            r.paddle_end = (s == 0) ? END_LEFT : END_RIGHT;
            r.hit_valid  = 1'b1;
            r.hit_time   = hit_t[left+s][i];
            r.hit_energy = hit_e[left+s][i];
            r.overflowed = ovf_mk[left+s];
            r.last       = 1'b0;
            fresh_hits.push_back(r);
          end
      if (fresh_hits.size() == 0) begin
        r = '0;
        r.paddle_end = END_LEFT;
        r.overflowed = ovf_mk[left] | ovf_mk[left+1];
        fresh_hits.push_back(r);
      end
      fresh_hits[fresh_hits.size()-1].last = 1'b1;
      hit_n[left] = 0;  hit_n[left+1] = 0;
      ovf_mk[left] = 0; ovf_mk[left+1] = 0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: every out_valid cycle is one transfer, no back-pressure.
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0d] %s: got %h want %h", cycles, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      hits_seen++;
      if (pending_hits.size() == 0) begin
        flag_mismatch("unexpected result", out_data[31:0], '0);
      end else begin
        want = pending_hits.pop_front();
        if (out_data.paddle_end !== want.paddle_end)
          flag_mismatch("paddle_end", out_data.paddle_end, want.paddle_end);
        if (out_data.hit_valid !== want.hit_valid)
          flag_mismatch("hit_valid", out_data.hit_valid, want.hit_valid);
        if (out_data.hit_time !== want.hit_time)
          flag_mismatch("hit_time", out_data.hit_time, want.hit_time);
        if (out_data.hit_energy !== want.hit_energy)
          flag_mismatch("hit_energy", out_data.hit_energy, want.hit_energy);
        if (out_data.overflowed !== want.overflowed)
          flag_mismatch("overflowed", out_data.overflowed, want.overflowed);
        if (out_data.last !== want.last)
          flag_mismatch("last", out_data.last, want.last);
      end
    end
  end

  // hard stop
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  typedef struct {
    in_t  it;
    bit   typed;   // expected result written into the row
    out_t want;
  } step_row_t;

  bit steady = 1'b0;  // no idle gaps while set

  function automatic in_t mk_item(logic kind, int layer, int row, int x, int t,
                                  int unsigned e);
    in_t it;
    it.kind           = kind;
    it.layer          = layer[1:0];
    it.row            = row[4:0];
    it.local_x        = x[15:0];
    it.step_time      = t;
    it.deposit_energy = e;
    return it;
  endfunction

  // Transfer one item; start drops at random cycles, busy or not.
  task automatic send_item(in_t it, bit typed = 1'b0, out_t want = '0);
    bit go;
    go      = steady || ($urandom_range(0, 99) >= 36);
    start   <= go;
    in_data <= it;
    forever begin
      @(posedge clk);
      if (go && !busy) break;
      go    = steady || ($urandom_range(0, 99) >= 36);
      start <= go;
    end
    predict_paddle(it);
    if (typed) pending_hits.push_back(want);
    else foreach (fresh_hits[i]) pending_hits.push_back(fresh_hits[i]);
    items_done++;
  endtask

  // Registers only change with the block drained and quiet.
  task automatic settle_block();
    start <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ATTEN:  atten_len = val[15:0];
      CFG_DELAY:  delay_pos = val[15:0];
      CFG_WINDOW: window    = val[15:0];
      CFG_THRESH: threshold = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [31:0] al, logic [31:0] dp, logic [31:0] mw,
                          logic [31:0] th);
    settle_block();
    write_reg(CFG_ATTEN, al);
    write_reg(CFG_DELAY, dp);
    write_reg(CFG_WINDOW, mw);
    write_reg(CFG_THRESH, th);
  endtask

  // Mostly clustered deposits on a few paddles so lists merge and fill,
  // readouts now and then, plus some fully random noise.
  function automatic in_t rand_item();
    in_t it;
    if ($urandom_range(0, 99) < 15) begin
      it.layer          = 2'($urandom);
      it.row            = 5'($urandom);
      it.local_x        = 16'($urandom);
      it.step_time      = $urandom;
      it.deposit_energy = $urandom;
      it.kind = ($urandom_range(0, 99) < 20);
      return it;
    end
    it.kind  = ($urandom_range(0, 99) < 22) ? KIND_READOUT : KIND_DEPOSIT;
    it.layer = ($urandom_range(0, 9) < 8) ? 2'($urandom_range(0, 1)) : 2'($urandom);
    it.row   = ($urandom_range(0, 9) < 8) ? 5'($urandom_range(0, 3)) : 5'($urandom);
    it.local_x = ($urandom_range(0, 9) < 7) ? 16'(int'($urandom_range(0, 4000)) - 2000)
                                            : 16'($urandom);
    it.step_time = ($urandom_range(0, 9) < 8) ? 32'(100000 + $urandom_range(0, 20000))
                                              : $urandom;
    case ($urandom_range(0, 9))
      0:       it.deposit_energy = 0;
      1, 2:    it.deposit_energy = $urandom;
      default: it.deposit_energy = $urandom_range(1, 2000000);
    endcase
    return it;
  endfunction

  step_row_t steps[$];
  out_t      empty_ro;

  initial begin
    atten_len = ATTEN_RST;
    delay_pos = DELAY_RST;
    window    = WINDOW_RST;
    threshold = THRESH_RST;
    foreach (hit_n[i]) begin
      hit_n[i]  = 0;
      ovf_mk[i] = 1'b0;
    end
    empty_ro      = '0;
    empty_ro.last = 1'b1;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows; empty readouts are typed in, the rest comes from the model
    steps.push_back('{mk_item(KIND_READOUT, 0, 0, 0, 0, 0), 1'b1, empty_ro});
    steps.push_back('{mk_item(KIND_DEPOSIT, 0, 0, 123, 5000, 0), 1'b0, '0});
    steps.push_back('{mk_item(KIND_READOUT, 0, 0, 0, 0, 0), 1'b1, empty_ro});
    // centered deposit: no shift, no attenuation
    steps.push_back('{mk_item(KIND_DEPOSIT, 1, 2, 0, 1000, 100000), 1'b0, '0});
    steps.push_back('{mk_item(KIND_DEPOSIT, 1, 2, 50, 1100, 300000), 1'b0, '0});
    steps.push_back('{mk_item(KIND_READOUT, 1, 2, 0, 0, 0), 1'b0, '0});
    // field extremes: time saturation, energy saturation on the far end
    steps.push_back('{mk_item(KIND_DEPOSIT, 3, 31, 32767, 32'h7FFF_FFFF, 32'hFFFF_FFFF),
                      1'b0, '0});
    steps.push_back('{mk_item(KIND_DEPOSIT, 3, 31, -32768, 32'h8000_0000, 32'hFFFF_FFFF),
                      1'b0, '0});
    steps.push_back('{mk_item(KIND_DEPOSIT, 3, 31, -32768, 32'h8000_0000, 32'hFFFF_FFFF),
                      1'b0, '0});
    steps.push_back('{mk_item(KIND_READOUT, 3, 31, 0, 0, 0), 1'b0, '0});
    // below threshold: kept but not reported
    steps.push_back('{mk_item(KIND_DEPOSIT, 2, 5, 0, 0, 1), 1'b0, '0});
    steps.push_back('{mk_item(KIND_READOUT, 2, 5, 0, 0, 0), 1'b1, empty_ro});
    // tiny deposit far along the bar: near end energy rounds to zero
    steps.push_back('{mk_item(KIND_DEPOSIT, 2, 6, 32767, -700, 1), 1'b0, '0});
    steps.push_back('{mk_item(KIND_READOUT, 2, 6, 0, 0, 0), 1'b0, '0});
    foreach (steps[i]) send_item(steps[i].it, steps[i].typed, steps[i].want);

    // no window, no threshold, shortest attenuation: fill one list past full
    set_regs(32'd1, 32'd0, 32'd0, 32'd0);
    for (int i = 0; i < 35; i++)
      send_item(mk_item(KIND_DEPOSIT, 1, 1, 3, 200 + i, 1000 + i));
    send_item(mk_item(KIND_READOUT, 1, 1, 0, 0, 0));

    // random phases across register settings, extremes included
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_regs(ATTEN_RST, DELAY_RST, WINDOW_RST, THRESH_RST);
        1: set_regs(32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF_FFFF);
        2: set_regs($urandom_range(1, 65535), $urandom_range(0, 65535),
                    $urandom_range(0, 4000), $urandom_range(0, 200000));
        default: set_regs(32'd1, 32'd0, 32'd0, 32'd0);
      endcase
      for (int i = 0; i < 18; i++) begin
        steady = (ph == 2);
        send_item(rand_item());
      end
      steady = 1'b0;
    end
    // flush the clustered paddles so every list on them gets reported
    for (int l = 0; l < 2; l++)
      for (int r = 0; r < 4; r++)
        send_item(mk_item(KIND_READOUT, l, r, 0, 0, 0));

    settle_block();
    if (pending_hits.size() != 0)
      flag_mismatch("results missing", pending_hits.size(), '0);
    $display("Run: %0d item transfers, %0d result transfers over %0d cycles",
             items_done, hits_seen, cycles);
    $display("Covered merges, list overflow, saturation and four register settings");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
